// ===== design/assert_macros.svh =====
// Assertion macros shared by the worker load balancer RTL.
// No dependencies; the checks expect signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge outside of reset.
`define WLB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked at every rising clock edge, reset included.
`define WLB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define WLB_ASSERT(lbl, prop, msg)
`define WLB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/wlb_pkg.sv =====
// Package for the worker load balancer: sizes, codes, interface structs.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wlb_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int IDX_W = $clog2(MAX_WORKERS);
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam int PORT_IDX_W = 4;
    localparam int LOAD_W = 16;
    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
    localparam logic [LOAD_W-1:0] FIXED_DEFAULT_COUNT = 16'd10;
    localparam logic [LOAD_W-1:0] FILL_DEFAULT_CAP = 16'd1000;

    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SLOT  = 2'd1,
        ST_NOT_LIVE = 2'd2
    } status_t;

    typedef enum logic {
        CFG_POOL_MODE = 1'b0,
        CFG_LIMIT     = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_SCAN,
        S_APPLY
    } state_t;

    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [LOAD_W-1:0] a;
        logic [LOAD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              lt;
        logic [LOAD_W-1:0] sum;
    } alu_rsp_t;

    typedef struct packed {
        logic              load_we;
        logic              live_we;
        logic              live_data;
        logic              clear_all;
        logic              build;
        logic [CNT_W-1:0]  build_n;
        logic [IDX_W-1:0]  addr;
        logic [LOAD_W-1:0] load_data;
    } slot_wr_t;

    function automatic logic [IDX_W-1:0] port_to_slot(input logic [PORT_IDX_W-1:0] p);
        logic [IDX_W+PORT_IDX_W-1:0] t;
        t = {{IDX_W{1'b0}}, p};
        return t[IDX_W-1:0];
    endfunction

    function automatic logic port_in_range(input logic [PORT_IDX_W-1:0] p);
        return (p < MAX_WORKERS);
    endfunction

    function automatic logic [PORT_IDX_W-1:0] slot_to_port(input logic [IDX_W-1:0] s);
        logic [IDX_W+PORT_IDX_W-1:0] t;
        t = {{PORT_IDX_W{1'b0}}, s};
        return t[PORT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/wlb_alu.sv =====
// Shared compare and saturating increment/decrement unit.
// Depends on wlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wlb_alu (
    input  wlb_pkg::alu_req_t req,
    output wlb_pkg::alu_rsp_t rsp
);

    always_comb
    begin
        rsp.lt = (req.a < req.b);
        unique case (req.op)
            wlb_pkg::ALU_INC:
            begin
                rsp.sum = (req.a == wlb_pkg::LOAD_MAX) ? req.a
                                                       : req.a + 1'b1;
            end
            wlb_pkg::ALU_DEC:
            begin
                rsp.sum = (req.a == '0) ? req.a : req.a - 1'b1;
            end
            default:
            begin
                rsp.sum = req.a;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/wlb_slot_file.sv =====
// Worker slot storage: live marks and load counts, one read and one write port.
// Depends on wlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wlb_slot_file (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wlb_pkg::slot_wr_t            wr,
    input  wire [wlb_pkg::IDX_W-1:0]     rd_addr,
    output logic [wlb_pkg::LOAD_W-1:0]   rd_load,
    output logic                         rd_live
);

    logic [wlb_pkg::LOAD_W-1:0] load_reg [wlb_pkg::MAX_WORKERS];
    logic [wlb_pkg::MAX_WORKERS-1:0] live_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wlb_pkg::MAX_WORKERS; i++)
            begin
                load_reg[i] <= '0;
            end
            live_reg <= '0;
        end
        else
        begin
            // pool build: the low build_n slots go live, loads are still zero
            if (wr.build)
            begin
                for (int i = 0; i < wlb_pkg::MAX_WORKERS; i++)
                begin
                    live_reg[i] <= (wlb_pkg::CNT_W'(i) < wr.build_n);
                end
            end
            if (wr.clear_all)
            begin
                for (int i = 0; i < wlb_pkg::MAX_WORKERS; i++)
                begin
                    load_reg[i] <= '0;
                end
            end
            if (wr.load_we)
            begin
                load_reg[wr.addr] <= wr.load_data;
            end
            if (wr.live_we)
            begin
                live_reg[wr.addr] <= wr.live_data;
            end
        end
    end

    assign rd_load = load_reg[rd_addr];
    assign rd_live = live_reg[rd_addr];

endmodule

`default_nettype wire

// ===== design/wlb_seq.sv =====
// Sequencer of the worker load balancer: config, pool build, slot scan, update.
// Depends on wlb_pkg, assert_macros.svh; drives wlb_slot_file and wlb_alu.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wlb_seq (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire [0:0]                        cfg_index,
    input  wire [15:0]                       cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [1:0]                        command,
    input  wire [wlb_pkg::PORT_IDX_W-1:0]    worker_index,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [wlb_pkg::PORT_IDX_W-1:0]   chosen_worker,
    output logic [1:0]                       status,
    output logic [wlb_pkg::LOAD_W-1:0]       new_load,
    output logic                             retired,
    output wlb_pkg::slot_wr_t                slot_wr,
    output logic [wlb_pkg::IDX_W-1:0]        slot_rd_addr,
    input  wire [wlb_pkg::LOAD_W-1:0]        slot_rd_load,
    input  wire                              slot_rd_live,
    output wlb_pkg::alu_req_t                alu_req,
    input  wlb_pkg::alu_rsp_t                alu_rsp
);

    wlb_pkg::state_t state_reg, state_next;
    wlb_pkg::cmd_t   cmd_reg, cmd_next;
    logic [wlb_pkg::PORT_IDX_W-1:0] idx_reg, idx_next;

    logic                       cfg_mode_reg, cfg_mode_next;
    logic [wlb_pkg::LOAD_W-1:0] cfg_limit_reg, cfg_limit_next;

    logic                       pool_ready_reg, pool_ready_next;
    logic                       mode_reg, mode_next;
    logic [wlb_pkg::LOAD_W-1:0] cap_reg, cap_next;
    logic [wlb_pkg::CNT_W-1:0]  total_reg, total_next;

    logic [wlb_pkg::IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                       found_reg, found_next;
    logic [wlb_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [wlb_pkg::LOAD_W-1:0] best_load_reg, best_load_next;
    logic                       free_found_reg, free_found_next;
    logic [wlb_pkg::IDX_W-1:0]  free_idx_reg, free_idx_next;

    logic                           out_valid_reg, out_valid_next;
    logic [wlb_pkg::PORT_IDX_W-1:0] out_chosen_reg, out_chosen_next;
    wlb_pkg::status_t               out_status_reg, out_status_next;
    logic [wlb_pkg::LOAD_W-1:0]     out_load_reg, out_load_next;
    logic                           out_retired_reg, out_retired_next;

    logic                       accept;
    logic                       scan_last;
    logic                       fill_hit;
    logic                       apply_go;
    logic [wlb_pkg::LOAD_W-1:0] fixed_n16;
    logic [wlb_pkg::CNT_W-1:0]  fixed_n;
    logic [wlb_pkg::IDX_W-1:0]  rel_slot;
    logic                       rel_ok;

    assign accept    = in_valid && (state_reg == wlb_pkg::S_IDLE);
    assign scan_last = (scan_idx_reg == wlb_pkg::IDX_W'(wlb_pkg::MAX_WORKERS - 1));
    assign fill_hit  = mode_reg && slot_rd_live && alu_rsp.lt;
    assign apply_go  = !out_valid_reg || !out_stall;
    assign rel_slot  = wlb_pkg::port_to_slot(idx_reg);
    assign rel_ok    = wlb_pkg::port_in_range(idx_reg);

    // fixed pool size: zero means default, then clamp to the slot count
    assign fixed_n16 = (cfg_limit_reg == '0) ? wlb_pkg::FIXED_DEFAULT_COUNT : cfg_limit_reg;
    assign fixed_n   = (fixed_n16 > wlb_pkg::LOAD_W'(wlb_pkg::MAX_WORKERS))
                       ? wlb_pkg::CNT_W'(wlb_pkg::MAX_WORKERS)
                       : fixed_n16[wlb_pkg::CNT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wlb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!pool_ready_reg)
                        state_next = wlb_pkg::S_BUILD;
                    else if (wlb_pkg::cmd_t'(command) == wlb_pkg::CMD_ACQUIRE)
                        state_next = wlb_pkg::S_SCAN;
                    else
                        state_next = wlb_pkg::S_APPLY;
                end
            end
            wlb_pkg::S_BUILD:
            begin
                state_next = (cmd_reg == wlb_pkg::CMD_ACQUIRE) ? wlb_pkg::S_SCAN
                                                               : wlb_pkg::S_APPLY;
            end
            wlb_pkg::S_SCAN:
            begin
                if (fill_hit || scan_last)
                    state_next = wlb_pkg::S_APPLY;
            end
            wlb_pkg::S_APPLY:
            begin
                if (apply_go)
                    state_next = wlb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = wlb_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        cfg_mode_next    = cfg_mode_reg;
        cfg_limit_next   = cfg_limit_reg;
        pool_ready_next  = pool_ready_reg;
        mode_next        = mode_reg;
        cap_next         = cap_reg;
        total_next       = total_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_load_next   = best_load_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_chosen_next  = out_chosen_reg;
        out_status_next  = out_status_reg;
        out_load_next    = out_load_reg;
        out_retired_next = out_retired_reg;

        slot_wr      = '0;
        slot_rd_addr = scan_idx_reg;
        alu_req.op   = wlb_pkg::ALU_INC;
        alu_req.a    = slot_rd_load;
        alu_req.b    = mode_reg ? cap_reg : best_load_reg;

        if (cfg_wr_en)
        begin
            unique case (wlb_pkg::cfg_idx_t'(cfg_index))
                wlb_pkg::CFG_POOL_MODE: cfg_mode_next  = cfg_data[0];
                wlb_pkg::CFG_LIMIT:     cfg_limit_next = cfg_data;
                default:                cfg_limit_next = cfg_limit_reg;
            endcase
        end

        unique case (state_reg)
            wlb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = wlb_pkg::cmd_t'(command);
                    idx_next        = worker_index;
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            wlb_pkg::S_BUILD:
            begin
                pool_ready_next = 1'b1;
                mode_next       = cfg_mode_reg;
                cap_next        = (cfg_limit_reg == '0) ? wlb_pkg::FILL_DEFAULT_CAP
                                                        : cfg_limit_reg;
                total_next      = cfg_mode_reg ? wlb_pkg::CNT_W'(1) : fixed_n;
                slot_wr.build   = 1'b1;
                slot_wr.build_n = cfg_mode_reg ? wlb_pkg::CNT_W'(1) : fixed_n;
            end
            wlb_pkg::S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (mode_reg)
                begin
                    if (fill_hit)
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = scan_idx_reg;
                        best_load_next = slot_rd_load;
                    end
                    // remember the lowest free slot in the same pass
                    if (!slot_rd_live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                end
                else if (slot_rd_live && (!found_reg || alu_rsp.lt))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_idx_reg;
                    best_load_next = slot_rd_load;
                end
            end
            wlb_pkg::S_APPLY:
            begin
                slot_rd_addr = rel_slot;
                if (apply_go)
                begin
                    out_valid_next   = 1'b1;
                    out_chosen_next  = '0;
                    out_status_next  = wlb_pkg::ST_OK;
                    out_load_next    = '0;
                    out_retired_next = 1'b0;
                    case (cmd_reg)
                        wlb_pkg::CMD_ACQUIRE:
                        begin
                            if (found_reg)
                            begin
                                alu_req.a         = best_load_reg;
                                slot_wr.load_we   = 1'b1;
                                slot_wr.addr      = best_idx_reg;
                                slot_wr.load_data = alu_rsp.sum;
                                out_chosen_next   = wlb_pkg::slot_to_port(best_idx_reg);
                                out_load_next     = alu_rsp.sum;
                            end
                            else if (mode_reg && free_found_reg)
                            begin
                                alu_req.a         = '0;
                                slot_wr.load_we   = 1'b1;
                                slot_wr.live_we   = 1'b1;
                                slot_wr.live_data = 1'b1;
                                slot_wr.addr      = free_idx_reg;
                                slot_wr.load_data = alu_rsp.sum;
                                total_next        = total_reg + 1'b1;
                                out_chosen_next   = wlb_pkg::slot_to_port(free_idx_reg);
                                out_load_next     = alu_rsp.sum;
                            end
                            else
                            begin
                                out_status_next = wlb_pkg::ST_NO_SLOT;
                            end
                        end
                        wlb_pkg::CMD_RELEASE:
                        begin
                            out_chosen_next = idx_reg;
                            alu_req.op      = wlb_pkg::ALU_DEC;
                            alu_req.a       = slot_rd_load;
                            if (!rel_ok || !slot_rd_live)
                            begin
                                out_status_next = wlb_pkg::ST_NOT_LIVE;
                            end
                            else
                            begin
                                out_load_next = alu_rsp.sum;
                                if (slot_rd_load != '0)
                                begin
                                    slot_wr.load_we   = 1'b1;
                                    slot_wr.addr      = rel_slot;
                                    slot_wr.load_data = alu_rsp.sum;
                                    // capacity mode retires a slot that drains to zero unless it is the only live slot
                                    if (mode_reg && (alu_rsp.sum == '0)
                                        && (total_reg > wlb_pkg::CNT_W'(1)))
                                    begin
                                        slot_wr.live_we   = 1'b1;
                                        slot_wr.live_data = 1'b0;
                                        total_next        = total_reg - 1'b1;
                                        out_retired_next  = 1'b1;
                                    end
                                end
                            end
                        end
                        wlb_pkg::CMD_CLEAR:
                        begin
                            slot_wr.clear_all = 1'b1;
                        end
                        default:
                        begin
                            slot_wr.clear_all = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                slot_wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wlb_pkg::S_IDLE;
            cfg_mode_reg   <= 1'b0;
            cfg_limit_reg  <= '0;
            pool_ready_reg <= 1'b0;
            mode_reg       <= 1'b0;
            cap_reg        <= '0;
            total_reg      <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_mode_reg   <= cfg_mode_next;
            cfg_limit_reg  <= cfg_limit_next;
            pool_ready_reg <= pool_ready_next;
            mode_reg       <= mode_next;
            cap_reg        <= cap_next;
            total_reg      <= total_next;
            scan_idx_reg   <= scan_idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        idx_reg         <= idx_next;
        best_idx_reg    <= best_idx_next;
        best_load_reg   <= best_load_next;
        free_idx_reg    <= free_idx_next;
        out_chosen_reg  <= out_chosen_next;
        out_status_reg  <= out_status_next;
        out_load_reg    <= out_load_next;
        out_retired_reg <= out_retired_next;
    end

    assign in_stall      = (state_reg != wlb_pkg::S_IDLE);
    assign out_valid     = out_valid_reg;
    assign chosen_worker = out_chosen_reg;
    assign status        = out_status_reg;
    assign new_load      = out_load_reg;
    assign retired       = out_retired_reg;

    `WLB_ASSERT(a_scan_step, (state_reg == wlb_pkg::S_SCAN) |=> ((state_reg == wlb_pkg::S_APPLY) || ((state_reg == wlb_pkg::S_SCAN) && (scan_idx_reg == $past(scan_idx_reg) + 1'b1))), "scan skipped or repeated a slot")
    `WLB_ASSERT(a_apply_holds, ((state_reg == wlb_pkg::S_APPLY) && out_valid_reg && out_stall) |=> ((state_reg == wlb_pkg::S_APPLY) && out_valid_reg), "result overwritten while output stalled")
    `WLB_ASSERT(a_retire_clean, (out_valid_reg && out_retired_reg) |-> ((out_status_reg == wlb_pkg::ST_OK) && (out_load_reg == '0) && mode_reg), "retire with nonzero load or bad status")
    `WLB_ASSERT(a_build_once, (state_reg == wlb_pkg::S_BUILD) |-> !pool_ready_reg, "pool built twice")
    `WLB_ASSERT(a_total_range, total_reg <= wlb_pkg::CNT_W'(wlb_pkg::MAX_WORKERS), "live slot count above slot total")

endmodule

`default_nettype wire

// ===== design/worker_load_balancer.sv =====
// Top level of the worker load balancer: sequencer, slot storage, shared ALU.
// Depends on wlb_pkg, wlb_alu, wlb_slot_file, wlb_seq.
//
//  channel | signals                                      | beat when
//  cfg     | cfg_wr_en, cfg_index, cfg_data               | cfg_wr_en high
//  in      | in_valid, in_stall, command, worker_index    | in_valid && !in_stall
//  out     | out_valid, out_stall, chosen_worker, status, | out_valid && !out_stall
//          | new_load, retired                            |
//
// Acquire walks all MAX_WORKERS slots through the one compare unit, one slot a
// cycle, or stops early in capacity mode on a hit under the cap.
// Release, clear and no-op skip the scan. The first beat after reset builds the pool.
// in_stall is high from the accepted beat until the result is in the output register.
// A stalled result holds; the next beat is taken meanwhile and waits at its update step.
// Reset is asynchronous and clears all slots and the pool; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module worker_load_balancer (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire [0:0]                        cfg_index,
    input  wire [15:0]                       cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [1:0]                        command,
    input  wire [wlb_pkg::PORT_IDX_W-1:0]    worker_index,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [wlb_pkg::PORT_IDX_W-1:0]   chosen_worker,
    output logic [1:0]                       status,
    output logic [wlb_pkg::LOAD_W-1:0]       new_load,
    output logic                             retired
);

    wlb_pkg::slot_wr_t          slot_wr;
    logic [wlb_pkg::IDX_W-1:0]  slot_rd_addr;
    logic [wlb_pkg::LOAD_W-1:0] slot_rd_load;
    logic                       slot_rd_live;
    wlb_pkg::alu_req_t          alu_req;
    wlb_pkg::alu_rsp_t          alu_rsp;

    wlb_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .worker_index  (worker_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chosen_worker (chosen_worker),
        .status        (status),
        .new_load      (new_load),
        .retired       (retired),
        .slot_wr       (slot_wr),
        .slot_rd_addr  (slot_rd_addr),
        .slot_rd_load  (slot_rd_load),
        .slot_rd_live  (slot_rd_live),
        .alu_req       (alu_req),
        .alu_rsp       (alu_rsp)
    );

    wlb_slot_file u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (slot_wr),
        .rd_addr (slot_rd_addr),
        .rd_load (slot_rd_load),
        .rd_live (slot_rd_live)
    );

    wlb_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule

`default_nettype wire

// ===== bench/tb_worker_load_balancer.sv =====
// Self-checking bench for worker_load_balancer: random and directed command beats,
// with a scoreboard class that tracks slot loads and checks every result beat.
// Depends on wlb_pkg and the worker_load_balancer RTL.
`timescale 1ns / 1ps

module tb_worker_load_balancer;
    import wlb_pkg::*;

    typedef struct packed {
        logic [PORT_IDX_W-1:0] worker;
        status_t               st;
        logic [LOAD_W-1:0]     load;
        logic                  retired;
    } lb_result_t;

    // Tracks the pool the way the block should: slot live marks, loads, built config.
    class lb_scoreboard;
        bit                mode_reg;
        bit [LOAD_W-1:0]   limit_reg;
        bit                built;
        bit                built_mode;
        int                cap;
        int                live_count;
        bit                live[MAX_WORKERS];
        bit [LOAD_W-1:0]   load[MAX_WORKERS];
        lb_result_t        expected[$];
        int                errors;

        function void write_reg(cfg_idx_t idx, logic [15:0] data);
            if (idx == CFG_POOL_MODE)
                mode_reg = data[0];
            else
                limit_reg = data;
        endfunction

        function void note_beat(cmd_t cmd, logic [PORT_IDX_W-1:0] idx);
            lb_result_t r;
            int found;
            int n;
            r = '0;
            found = -1;
            // pool is built from the registers on the very first beat
            if (!built)
            begin
                built_mode = mode_reg;
                n = limit_reg;
                if (!built_mode)
                begin
                    if (n == 0)
                        n = FIXED_DEFAULT_COUNT;
                    if (n > MAX_WORKERS)
                        n = MAX_WORKERS;
                    for (int i = 0; i < n; i++)
                    begin
                        live[i] = 1'b1;
                        load[i] = '0;
                    end
                    live_count = n;
                    cap = 0;
                end
                else
                begin
                    cap = (limit_reg == 0) ? int'(FILL_DEFAULT_CAP) : int'(limit_reg);
                    live[0] = 1'b1;
                    load[0] = '0;
                    live_count = 1;
                end
                built = 1'b1;
            end
            case (cmd)
                CMD_ACQUIRE:
                begin
                    if (!built_mode)
                    begin
                        for (int i = 0; i < MAX_WORKERS; i++)
                            if (live[i] && (found < 0 || load[i] < load[found]))
                                found = i;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_WORKERS; i++)
                            if (found < 0 && live[i] && load[i] < cap)
                                found = i;
                        // nothing under capacity: open the lowest free slot
                        if (found < 0)
                        begin
                            for (int i = 0; i < MAX_WORKERS; i++)
                                if (found < 0 && !live[i])
                                begin
                                    live[i] = 1'b1;
                                    load[i] = '0;
                                    live_count++;
                                    found = i;
                                end
                        end
                    end
                    if (found < 0)
                        r.st = ST_NO_SLOT;
                    else
                    begin
                        if (load[found] != LOAD_MAX)
                            load[found] = load[found] + 1'b1;
                        r.worker = PORT_IDX_W'(found);
                        r.load = load[found];
                    end
                end
                CMD_RELEASE:
                begin
                    r.worker = idx;
                    if (idx >= MAX_WORKERS || !live[idx])
                        r.st = ST_NOT_LIVE;
                    else
                    begin
                        if (load[idx] != 0)
                        begin
                            load[idx] = load[idx] - 1'b1;
                            if (built_mode && load[idx] == 0 && live_count > 1)
                            begin
                                live[idx] = 1'b0;
                                live_count--;
                                r.retired = 1'b1;
                            end
                        end
                        r.load = load[idx];
                    end
                end
                CMD_CLEAR:
                begin
                    for (int i = 0; i < MAX_WORKERS; i++)
                        load[i] = '0;
                end
                default: ;
            endcase
            expected.push_back(r);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [PORT_IDX_W-1:0] worker, logic [1:0] st,
                          logic [LOAD_W-1:0] ld, logic ret);
            lb_result_t e;
            if (expected.size() == 0)
            begin
                report_mismatch("result beat with nothing pending, worker", worker, 0);
                return;
            end
            e = expected.pop_front();
            if (worker !== e.worker)
                report_mismatch("chosen_worker", worker, e.worker);
            if (st !== e.st)
                report_mismatch("status", st, e.st);
            if (ld !== e.load)
                report_mismatch("new_load", ld, e.load);
            if (ret !== e.retired)
                report_mismatch("retired", ret, e.retired);
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [0:0]             cfg_index = '0;
    logic [15:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             command = '0;
    logic [PORT_IDX_W-1:0]  worker_index = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PORT_IDX_W-1:0]  chosen_worker;
    logic [1:0]             status;
    logic [LOAD_W-1:0]      new_load;
    logic                   retired;

    lb_scoreboard sb = new();
    bit calm = 1'b0;
    int acquire_pct = 50;

    worker_load_balancer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .worker_index(worker_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .chosen_worker(chosen_worker),
        .status(status),
        .new_load(new_load),
        .retired(retired)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(chosen_worker, status, new_load, retired);
    end

    initial
    begin
        #2000000;
        $display("worker_load_balancer: mismatch");
        $finish;
    end

    // both registers, back to back; the block ignores them once the pool exists
    task write_regs(logic mode, logic [15:0] lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_POOL_MODE;
        cfg_data <= {15'd0, mode};
        @(posedge clk);
        sb.write_reg(CFG_POOL_MODE, {15'd0, mode});
        cfg_index <= CFG_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        sb.write_reg(CFG_LIMIT, lim);
        cfg_wr_en <= 1'b0;
    endtask

    task sender_gap();
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 33)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task send_beat(cmd_t cmd, logic [PORT_IDX_W-1:0] idx);
        sender_gap();
        in_valid <= 1'b1;
        command <= cmd;
        worker_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(cmd, idx);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly releases of slots that hold load, so loads move both ways
    function automatic logic [PORT_IDX_W-1:0] release_target();
        logic [PORT_IDX_W-1:0] p;
        if ($urandom_range(0, 4) != 0)
        begin
            for (int k = 0; k < 8; k++)
            begin
                p = $urandom_range(0, 15);
                if (sb.live[p] && sb.load[p] != 0)
                    return p;
            end
        end
        return $urandom_range(0, 15);
    endfunction

    task random_beat();
        int r;
        r = $urandom_range(0, 99);
        if (r < acquire_pct)
            send_beat(CMD_ACQUIRE, $urandom_range(0, 15));
        else if (r < 93)
            send_beat(CMD_RELEASE, release_target());
        else if (r < 97)
            send_beat(CMD_CLEAR, $urandom_range(0, 15));
        else
            send_beat(CMD_NOP, $urandom_range(0, 15));
    endtask

    localparam int N_DIRECTED = 22;
    localparam logic [5:0] DIRECTED [N_DIRECTED] = '{
        {CMD_NOP, 4'd15}, {CMD_ACQUIRE, 4'd0}, {CMD_ACQUIRE, 4'd15},
        {CMD_ACQUIRE, 4'd7}, {CMD_ACQUIRE, 4'd0}, {CMD_RELEASE, 4'd0},
        {CMD_RELEASE, 4'd0}, {CMD_RELEASE, 4'd0}, {CMD_RELEASE, 4'd15},
        {CMD_RELEASE, 4'd1}, {CMD_RELEASE, 4'd9}, {CMD_CLEAR, 4'd3},
        {CMD_RELEASE, 4'd2}, {CMD_ACQUIRE, 4'd0}, {CMD_ACQUIRE, 4'd0},
        {CMD_ACQUIRE, 4'd0}, {CMD_RELEASE, 4'd1}, {CMD_RELEASE, 4'd1},
        {CMD_NOP, 4'd0}, {CMD_RELEASE, 4'd10}, {CMD_ACQUIRE, 4'd0},
        {CMD_CLEAR, 4'd0}
    };

    initial
    begin
        logic        mode;
        logic [15:0] lim;
        mode = $urandom_range(0, 1);
        case ($urandom_range(0, 7))
            0: lim = 16'd0;
            1: lim = 16'd1;
            2: lim = 16'd2;
            3: lim = $urandom_range(3, 15);
            4: lim = 16'd16;
            5: lim = 16'd17;
            6: lim = 16'hFFFF;
            default: lim = $urandom_range(18, 65534);
        endcase
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // first write is overwritten before the pool is built
        write_regs(~mode, ~lim);
        @(posedge clk);
        write_regs(mode, lim);

        foreach (DIRECTED[i])
            send_beat(cmd_t'(DIRECTED[i][5:4]), DIRECTED[i][3:0]);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            calm = (ph == 2);
            acquire_pct = (ph % 2) ? 68 : 42;
            for (int n = 0; n < 500; n++)
                random_beat();
            // sender holds off until every result is back, then pokes the registers
            drain();
            case (ph)
                0: write_regs(1'b1, 16'hFFFF);
                1: write_regs(1'b0, 16'd0);
                default: write_regs($urandom_range(0, 1), $urandom_range(0, 65535));
            endcase
        end
        calm = 1'b0;

        drain();
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results never returned", 0, sb.pending());
        if (sb.errors == 0)
            $display("worker_load_balancer: match");
        else
            $display("worker_load_balancer: mismatch");
        $finish;
    end

endmodule
